// File: rtl/media_clock_timestamp_map_core_defines.svh
// assertion macros for the timestamp map core
`ifndef MEDIA_CLOCK_TIMESTAMP_MAP_CORE_DEFINES_SVH
`define MEDIA_CLOCK_TIMESTAMP_MAP_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define MCTM_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define MCTM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mctm_pkg.sv
package mctm_pkg;

  localparam int DIV_STEPS = 64;

  localparam logic [29:0] NS_PER_S  = 30'd1000000000;
  localparam logic [29:0] Q16_ONE   = 30'd65536;
  localparam logic [17:0] SCALE_MIN = 18'd32768;
  localparam logic [17:0] SCALE_MAX = 18'd131072;

  // register indexes
  localparam logic [2:0] REG_SAMPLE_RATE    = 3'd0;
  localparam logic [2:0] REG_ANCHOR_RTP     = 3'd1;
  localparam logic [2:0] REG_ANCHOR_TIME_NS = 3'd2;
  localparam logic [2:0] REG_PLAYOUT_OFFSET = 3'd3;
  localparam logic [2:0] REG_RATE_SCALE     = 3'd4;
  localparam logic [2:0] REG_MAP_VALID      = 3'd5;

  typedef struct packed {
    logic              operation;
    logic [31:0]       rtp_timestamp;
    logic signed [63:0] network_time_ns;
  } query_t;

  typedef struct packed {
    logic              ok;
    logic signed [63:0] result_network_ns;
    logic [31:0]       result_rtp;
  } result_t;

  typedef struct packed {
    logic [19:0] samp_rate;
    logic [31:0] anchor_ts;
    logic [62:0] anchor_time_ns;
    logic [63:0] playout_offset;
    logic [17:0] rate_scale;
    logic        map_valid;
    logic [63:0] base;
    logic        enable;
  } cfg_t;

  // sideband carried through the dividers
  typedef struct packed {
    logic ok;
    logic op;
    logic neg;
  } ctx_t;

endpackage

// File: rtl/mctm_regs.sv
module mctm_regs (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [5:0]     paddr,
  input  logic [63:0]    pwdata,
  output logic [63:0]    prdata,
  output mctm_pkg::cfg_t cfg
);
  import mctm_pkg::*;

  logic       wr;
  logic [2:0] idx;
  logic [17:0] scale_raw;
  logic [17:0] scale_sat;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[5:3];

  // saturate rate scale writes
  always_comb begin
    scale_raw = pwdata[17:0];
    if (scale_raw < SCALE_MIN) begin
      scale_sat = SCALE_MIN;
    end else if (scale_raw > SCALE_MAX) begin
      scale_sat = SCALE_MAX;
    end else begin
      scale_sat = scale_raw;
    end
  end

  // register file, derived terms settle in the cycle after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samp_rate      <= 20'd1;
      cfg.anchor_ts      <= '0;
      cfg.anchor_time_ns <= '0;
      cfg.playout_offset <= '0;
      cfg.rate_scale     <= Q16_ONE[17:0];
      cfg.map_valid      <= 1'b0;
      cfg.base           <= '0;
      cfg.enable         <= 1'b0;
    end else begin
      if (wr) begin
        case (idx)
          REG_SAMPLE_RATE:    cfg.samp_rate      <= pwdata[19:0];
          REG_ANCHOR_RTP:     cfg.anchor_ts      <= pwdata[31:0];
          REG_ANCHOR_TIME_NS: cfg.anchor_time_ns <= pwdata[62:0];
          REG_PLAYOUT_OFFSET: cfg.playout_offset <= pwdata;
          REG_RATE_SCALE:     cfg.rate_scale     <= scale_sat;
          REG_MAP_VALID:      cfg.map_valid      <= pwdata[0];
          default: ;
        endcase
      end
      cfg.base   <= {1'b0, cfg.anchor_time_ns} + cfg.playout_offset;
      cfg.enable <= cfg.map_valid && (cfg.samp_rate != 20'd0);
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_SAMPLE_RATE:    prdata = {44'd0, cfg.samp_rate};
      REG_ANCHOR_RTP:     prdata = {32'd0, cfg.anchor_ts};
      REG_ANCHOR_TIME_NS: prdata = {1'b0, cfg.anchor_time_ns};
      REG_PLAYOUT_OFFSET: prdata = cfg.playout_offset;
      REG_RATE_SCALE:     prdata = {46'd0, cfg.rate_scale};
      REG_MAP_VALID:      prdata = {63'd0, cfg.map_valid};
      default:            prdata = '0;
    endcase
  end

endmodule

// File: rtl/mctm_div.sv
module mctm_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mctm_pkg::ctx_t in_ctx,
  input  logic [63:0]    dividend,
  input  logic [29:0]    divisor,
  output logic           out_valid,
  output mctm_pkg::ctx_t out_ctx,
  output logic [63:0]    quotient
);
  import mctm_pkg::*;

  logic [DIV_STEPS:0] vld;
  logic [63:0]        w  [0:DIV_STEPS];
  logic [29:0]        r  [0:DIV_STEPS];
  logic [29:0]        dv [0:DIV_STEPS];
  ctx_t               cx [0:DIV_STEPS];

  // input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    w[0]  <= dividend;
    r[0]  <= '0;
    dv[0] <= divisor;
    cx[0] <= in_ctx;
  end

  // one quotient bit per stage, restoring
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [30:0] t;
    logic [30:0] diff;
    logic        ge;

    always_comb begin
      t    = {r[k-1], w[k-1][63]};
      diff = t - {1'b0, dv[k-1]};
      ge   = (t >= {1'b0, dv[k-1]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      r[k]  <= ge ? diff[29:0] : t[29:0];
      w[k]  <= {w[k-1][62:0], ge};
      dv[k] <= dv[k-1];
      cx[k] <= cx[k-1];
    end
  end

  assign out_valid = vld[DIV_STEPS];
  assign out_ctx   = cx[DIV_STEPS];
  assign quotient  = w[DIV_STEPS];

endmodule

// File: rtl/media_clock_timestamp_map_core.sv
// Timestamp map core: converts RTP timestamps to network nanoseconds (operation 0)
// and back (operation 1). One query may start every cycle and busy stays low;
// each result passes through two pipelined dividers of 65 stages each (an input
// register, then one quotient bit a stage) plus six arithmetic stages. The result
// strobe lasts one cycle and cannot be held off. Registers are written over the APB
// port at byte address 8*index and must only change with no query in flight; derived
// terms settle in the cycle after the last write.
`include "media_clock_timestamp_map_core_defines.svh"

module media_clock_timestamp_map_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mctm_pkg::query_t  query,
  output logic              result_valid,
  output mctm_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import mctm_pkg::*;

  cfg_t cfg;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  mctm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // stage 1: delta to the anchor
  logic        s1_valid;
  ctx_t        s1_ctx;
  logic [63:0] s1_d;
  logic [31:0] rtp_delta;

  assign rtp_delta = query.rtp_timestamp - cfg.anchor_ts;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_ctx.ok  <= cfg.enable;
    s1_ctx.op  <= query.operation;
    s1_ctx.neg <= 1'b0;
    s1_d <= query.operation ? (query.network_time_ns - cfg.base)
                            : {{32{rtp_delta[31]}}, rtp_delta};
  end

  // stage 2: partial products of delta times sample rate
  logic        s2_valid;
  ctx_t        s2_ctx;
  logic [63:0] s2_d;
  logic [51:0] s2_pl;
  logic [51:0] s2_ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_ctx <= s1_ctx;
    s2_d   <= s1_d;
    s2_pl  <= s1_d[31:0] * cfg.samp_rate;
    s2_ph  <= s1_d[63:32] * cfg.samp_rate;
  end

  // stage 3: wrapped dividend
  logic        s3_valid;
  ctx_t        s3_ctx;
  logic [63:0] s3_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_ctx <= s2_ctx;
    s3_p   <= s2_ctx.op ? ({12'd0, s2_pl} + {s2_ph[31:0], 32'd0})
                        : {s2_d[47:0], 16'd0};
  end

  // first divider: by rate scale or by one second
  ctx_t        da_ctx_in;
  logic [63:0] da_mag;
  logic [29:0] da_divisor;
  logic        da_valid;
  ctx_t        da_ctx;
  logic [63:0] da_q;

  always_comb begin
    da_ctx_in     = s3_ctx;
    da_ctx_in.neg = s3_p[63];
    da_mag        = s3_p[63] ? (64'd0 - s3_p) : s3_p;
    da_divisor    = s3_ctx.op ? NS_PER_S : {12'd0, cfg.rate_scale};
  end

  mctm_div u_div_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ctx    (da_ctx_in),
    .dividend  (da_mag),
    .divisor   (da_divisor),
    .out_valid (da_valid),
    .out_ctx   (da_ctx),
    .quotient  (da_q)
  );

  // middle product on the magnitude
  logic        m_valid;
  ctx_t        m_ctx;
  logic [63:0] m_p;
  logic [29:0] m_factor;

  assign m_factor = da_ctx.op ? {12'd0, cfg.rate_scale} : NS_PER_S;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= da_valid;
    end
    m_ctx <= da_ctx;
    m_p   <= da_q[33:0] * m_factor;
  end

  // second divider: by sample rate or by Q16 one
  logic [29:0] db_divisor;
  logic        db_valid;
  ctx_t        db_ctx;
  logic [63:0] db_q;

  assign db_divisor = m_ctx.op ? Q16_ONE : {10'd0, cfg.samp_rate};

  mctm_div u_div_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (m_valid),
    .in_ctx    (m_ctx),
    .dividend  (m_p),
    .divisor   (db_divisor),
    .out_valid (db_valid),
    .out_ctx   (db_ctx),
    .quotient  (db_q)
  );

  // restore the sign
  logic        n_valid;
  ctx_t        n_ctx;
  logic [63:0] n_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_valid <= 1'b0;
    end else begin
      n_valid <= db_valid;
    end
    n_ctx <= db_ctx;
    n_q   <= db_ctx.neg ? (64'd0 - db_q) : db_q;
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= n_valid;
    end
    result.ok                <= n_ctx.ok;
    result.result_network_ns <= (n_ctx.ok && !n_ctx.op) ? (cfg.base + n_q) : '0;
    result.result_rtp        <= (n_ctx.ok && n_ctx.op) ? (cfg.anchor_ts + n_q[31:0]) : '0;
  end

  // checks
  `MCTM_ASSERT_IMPL(a_invalid_zero, clk, rst, result_valid && !result.ok, result.result_network_ns == 64'd0 && result.result_rtp == 32'd0, "invalid map gave nonzero result")
  `MCTM_ASSERT_IMPL(a_scale_range, clk, rst, 1'b1, cfg.rate_scale >= SCALE_MIN && cfg.rate_scale <= SCALE_MAX, "rate scale out of range")
  `MCTM_ASSERT_NEXT(a_sign_cleared, clk, rst, start && !busy, s1_valid && !s1_ctx.neg, "accepted word lost at stage one")

endmodule

// File: dv/tb_media_clock_timestamp_map_core.sv
`timescale 1ns / 1ps

module tb_media_clock_timestamp_map_core;
  import mctm_pkg::*;

  localparam bit OP_TO_NET = 1'b0;
  localparam bit OP_TO_RTP = 1'b1;
  localparam int DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  query_t      query;
  logic        result_valid;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  media_clock_timestamp_map_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .query(query),
    .result_valid(result_valid), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the map registers
  logic [19:0] map_rate;
  logic [31:0] map_anchor_rtp;
  logic [62:0] map_anchor_ns;
  logic [63:0] map_offset;
  logic [17:0] map_scale;
  logic        map_on;

  result_t pending_words[$];
  int      mismatches;
  int      checked;
  int      sent;
  int      phases;

  typedef struct {
    query_t  q;
    bit      typed;
    result_t want;
  } row_t;
  row_t rows[$];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_media_clock_timestamp_map_core NOT OK");
    $finish;
  end

  function automatic void shadow_write(logic [2:0] idx, logic [63:0] v);
    logic [17:0] s;
    case (idx)
      REG_SAMPLE_RATE:    map_rate = v[19:0];
      REG_ANCHOR_RTP:     map_anchor_rtp = v[31:0];
      REG_ANCHOR_TIME_NS: map_anchor_ns = v[62:0];
      REG_PLAYOUT_OFFSET: map_offset = v;
      REG_RATE_SCALE: begin
        s = v[17:0];
        if (s < SCALE_MIN) s = SCALE_MIN;
        if (s > SCALE_MAX) s = SCALE_MAX;
        map_scale = s;
      end
      REG_MAP_VALID:      map_on = v[0];
      default: ;
    endcase
  endfunction

  // expected conversion for one query under the current map
  function automatic result_t map_timestamp(query_t q);
    result_t     r;
    longint      base;
    longint      d;
    logic [31:0] dr;
    r = '0;
    if (!map_on || map_rate == 0) return r;
    base = longint'({1'b0, map_anchor_ns}) + longint'(map_offset);
    if (q.operation == OP_TO_NET) begin
      dr = q.rtp_timestamp - map_anchor_rtp;
      d = longint'(int'(dr));
      d = (d * 64'sd65536) / longint'({46'd0, map_scale});
      d = (d * 64'sd1000000000) / longint'({44'd0, map_rate});
      r.result_network_ns = base + d;
    end else begin
      d = longint'(q.network_time_ns) - base;
      d = (d * longint'({44'd0, map_rate})) / 64'sd1000000000;
      d = (d * longint'({46'd0, map_scale})) / 64'sd65536;
      r.result_rtp = map_anchor_rtp + d[31:0];
    end
    r.ok = 1'b1;
    return r;
  endfunction

  // apb write, setup then access
  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_write(idx, v);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // hold start until the word is taken
  task automatic send_word(query_t q, bit typed, result_t want);
    @(negedge clk);
    start <= 1'b1;
    query <= q;
    do @(posedge clk); while (busy);
    pending_words.push_back(typed ? want : map_timestamp(q));
    sent++;
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // let the pipe empty before touching registers
  task automatic drain;
    pause_sender(1);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic query_t mk(bit op, logic [31:0] rtp, logic [63:0] net);
    query_t q;
    q.operation = op;
    q.rtp_timestamp = rtp;
    q.network_time_ns = net;
    return q;
  endfunction

  function automatic result_t rs(bit ok, logic [63:0] net, logic [31:0] rtp);
    result_t r;
    r.ok = ok;
    r.result_network_ns = net;
    r.result_rtp = rtp;
    return r;
  endfunction

  task automatic run_rows(int lo, int hi);
    for (int i = lo; i < hi; i++) send_word(rows[i].q, rows[i].typed, rows[i].want);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // random map setting, extremes now and then
  task automatic random_map(int n);
    logic [63:0] v;
    case ($urandom_range(0, 6))
      0: v = 64'd1;
      1: v = 64'd768000;
      2: v = 64'd44100;
      3: v = 64'd48000;
      4: v = {44'd0, 20'hFFFFF};
      default: v = rnd64();
    endcase
    if (n == 3) v = 64'd0;
    reg_write(REG_SAMPLE_RATE, v);
    reg_write(REG_ANCHOR_RTP, ($urandom_range(0, 3) == 0) ? 64'hFFFF_FFFF : rnd64());
    reg_write(REG_ANCHOR_TIME_NS, ($urandom_range(0, 3) == 0) ? '1 : rnd64());
    case ($urandom_range(0, 4))
      0: v = 64'h8000_0000_0000_0000;
      1: v = 64'h7FFF_FFFF_FFFF_FFFF;
      2: v = 64'(longint'($urandom_range(0, 2000000)) - 64'sd1000000);
      default: v = rnd64();
    endcase
    reg_write(REG_PLAYOUT_OFFSET, v);
    case ($urandom_range(0, 4))
      0: v = 64'd0;
      1: v = '1;
      2: v = 64'd65536;
      default: v = rnd64();
    endcase
    reg_write(REG_RATE_SCALE, v);
    v = rnd64();
    v[0] = (n == 5) ? 1'b0 : ($urandom_range(0, 7) != 0);
    reg_write(REG_MAP_VALID, v);
  endtask

  function automatic query_t random_query();
    query_t      q;
    logic [63:0] base;
    q = mk(1'($urandom_range(0, 1)), $urandom, rnd64());
    base = {1'b0, map_anchor_ns} + map_offset;
    case ($urandom_range(0, 5))
      // close to the anchor, the usual case
      0, 1: begin
        q.rtp_timestamp = map_anchor_rtp + 32'($urandom_range(0, 400000)) - 32'd200000;
        q.network_time_ns = base + 64'(longint'($urandom_range(0, 200000000))
                                       - 64'sd100000000);
      end
      2: q.network_time_ns = base + {{32{1'b0}}, $urandom};
      3: begin
        q.rtp_timestamp = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h8000_0000;
        q.network_time_ns = $urandom_range(0, 1) ? 64'h8000_0000_0000_0000
                                                 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
      default: ;
    endcase
    return q;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", result);
      end else begin
        want = pending_words.pop_front();
        checked++;
        if (result.ok !== want.ok || result.result_network_ns !== want.result_network_ns
            || result.result_rtp !== want.result_rtp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ok=%b ns=%0d rtp=%h, got ok=%b ns=%0d rtp=%h",
                     want.ok, want.result_network_ns, want.result_rtp,
                     result.ok, result.result_network_ns, result.result_rtp);
        end
      end
    end
  end

  initial begin
    int burst;
    mismatches = 0; checked = 0; sent = 0; phases = 0;
    rst = 1'b1; start = 1'b0; query = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    map_rate = 20'd1; map_anchor_rtp = '0; map_anchor_ns = '0;
    map_offset = '0; map_scale = 18'd65536; map_on = 1'b0;

    // map invalid after reset, results all zero
    rows.push_back('{mk(OP_TO_NET, 32'd0, 64'd0), 1, rs(0, 64'd0, 32'd0)});
    rows.push_back('{mk(OP_TO_NET, '1, '1), 1, rs(0, 64'd0, 32'd0)});
    rows.push_back('{mk(OP_TO_RTP, 32'd5, 64'h8000_0000_0000_0000), 1, rs(0, 64'd0, 32'd0)});
    rows.push_back('{mk(OP_TO_RTP, '1, 64'h7FFF_FFFF_FFFF_FFFF), 1, rs(0, 64'd0, 32'd0)});
    // unity map: one sample a second
    rows.push_back('{mk(OP_TO_NET, 32'd1, 64'd0), 1, rs(1, 64'd1000000000, 32'd0)});
    rows.push_back('{mk(OP_TO_NET, '1, 64'd0), 1, rs(1, -64'sd1000000000, 32'd0)});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, 64'd1000000000), 1, rs(1, 64'd0, 32'd1)});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, -64'sd1000000000), 1, rs(1, 64'd0, '1)});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, 64'd999999999), 1, rs(1, 64'd0, 32'd0)});
    rows.push_back('{mk(OP_TO_NET, 32'h7FFF_FFFF, 64'd0), 0, '0});
    rows.push_back('{mk(OP_TO_NET, 32'h8000_0000, 64'd0), 0, '0});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF), 0, '0});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, 64'h8000_0000_0000_0000), 0, '0});
    // extreme map: wraps in every stage
    rows.push_back('{mk(OP_TO_NET, 32'd0, 64'd0), 0, '0});
    rows.push_back('{mk(OP_TO_NET, '1, 64'd0), 0, '0});
    rows.push_back('{mk(OP_TO_NET, 32'h7FFF_FFFF, 64'd0), 0, '0});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, 64'h8000_0000_0000_0000), 0, '0});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, 64'h7FFF_FFFF_FFFF_FFFF), 0, '0});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, '1), 0, '0});
    // zero sample rate behaves as an invalid map
    rows.push_back('{mk(OP_TO_NET, 32'd7, 64'd0), 1, rs(0, 64'd0, 32'd0)});
    rows.push_back('{mk(OP_TO_RTP, 32'd0, 64'd123456789), 1, rs(0, 64'd0, 32'd0)});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part
    run_rows(0, 4);
    drain();
    reg_write(REG_MAP_VALID, 64'd1);
    run_rows(4, 13);
    drain();
    reg_write(REG_SAMPLE_RATE, 64'hFFFF_FFFF_FFF0_0000 | 64'd768000);
    reg_write(REG_ANCHOR_RTP, '1);
    reg_write(REG_ANCHOR_TIME_NS, '1);
    reg_write(REG_PLAYOUT_OFFSET, 64'h8000_0000_0000_0000);
    reg_write(REG_RATE_SCALE, 64'd0);
    run_rows(13, 19);
    drain();
    reg_write(REG_SAMPLE_RATE, 64'd0);
    run_rows(19, rows.size());
    drain();

    // random part, new map every phase
    for (int ph = 0; ph < 9; ph++) begin
      random_map(ph);
      phases++;
      for (int n = 0; n < 160; ) begin
        burst = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
        for (int k = 0; k < burst && n < 160; k++, n++) send_word(random_query(), 0, '0);
        if ($urandom_range(0, 4) != 0) pause_sender($urandom_range(0, 6));
      end
      drain();
    end

    pause_sender(1);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d queries over %0d random map settings, %0d results checked",
             sent, phases, checked);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_media_clock_timestamp_map_core OK");
    end else begin
      $display("tb_media_clock_timestamp_map_core NOT OK");
    end
    $finish;
  end

endmodule
